// ----- hw/rtl/cmad_pkg.sv -----
// Shared types and constants for the centered moving-average detrend block.
// No dependencies; imported by every module of the block.
`default_nettype none

package cmad_pkg;

   localparam int MAX_HALF_WINDOW_DEF = 2047;
   localparam int SAMPLE_BITS_DEF     = 32;
   localparam int WEEK_W              = 16;
   localparam int MS_W                = 30;
   localparam int CFG_W               = 11;
   localparam logic [CFG_W-1:0] HALF_WINDOW_RESET = 11'd1500;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ_OLD,
      ST_WRITE,
      ST_READ_CTR,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_OUT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;     // latch input word and per-item control
      logic rd_old;      // read sample leaving the window
      logic write;       // write delay line, update sum and counters
      logic rd_center;   // read centered entry
      logic div_start;   // launch mean division
      logic load_out;    // move result into output register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic emit;        // this item produces a result
      logic div_done;    // quotient ready
      logic out_full;    // output register occupied and not drained this cycle
   } status_type;

endpackage

`default_nettype wire

// ----- hw/rtl/cmad_divider.sv -----
// Iterative unsigned restoring divider, two quotient bits per cycle.
// Uses cmad_pkg only for the common import style.
`default_nettype none

module cmad_divider
   import cmad_pkg::*;
#(
   parameter int NUM_W = 43,
   parameter int DEN_W = 12
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] dividend,
   input  wire logic [DEN_W-1:0] divisor,
   output logic                  done,
   output logic [NUM_W-1:0]      quotient
);

   localparam int STEPS  = (NUM_W + 1) / 2;
   localparam int PAD_W  = 2 * STEPS;
   localparam int STEP_W = $clog2(STEPS + 1);

   logic [PAD_W-1:0]  acc_ff, acc_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   // one restoring step: remainder stays below the divisor
   function automatic logic [DEN_W:0] div_step(input logic [DEN_W-1:0] r,
                                                input logic b,
                                                input logic [DEN_W-1:0] d);
      logic [DEN_W:0] t;
      logic [DEN_W:0] res;
      t = {r, b};
      if (t >= {1'b0, d}) begin
         res = {1'b1, DEN_W'(t - {1'b0, d})};
      end else begin
         res = {1'b0, t[DEN_W-1:0]};
      end
      return res;
   endfunction

   always_comb begin
      logic [DEN_W:0] s1;
      logic [DEN_W:0] s2;
      s1      = div_step(rem_ff, acc_ff[PAD_W-1], den_ff);
      s2      = div_step(s1[DEN_W-1:0], acc_ff[PAD_W-2], den_ff);
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = PAD_W'(dividend);
         rem_in  = '0;
         cnt_in  = STEP_W'(STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = {acc_ff[PAD_W-3:0], s1[DEN_W], s2[DEN_W]};
         rem_in = s2[DEN_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      if (start) begin
         den_ff <= divisor;
      end
   end

   assign done     = done_ff;
   assign quotient = acc_ff[NUM_W-1:0];

endmodule

`default_nettype wire

// ----- hw/rtl/cmad_datapath.sv -----
// Datapath: delay-line memory, exact window sum, counters, mean division and
// saturating residual with its output register. Uses cmad_pkg, cmad_divider.
`default_nettype none

module cmad_datapath
   import cmad_pkg::*;
#(
   parameter int MAX_HALF_WINDOW = MAX_HALF_WINDOW_DEF,
   parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_wr_en,
   input  wire logic [CFG_W-1:0]       csr_wr_data,
   input  wire cmd_type                cmd,
   output status_type                  status,
   input  wire logic [SAMPLE_BITS-1:0] in_sample,
   input  wire logic [WEEK_W-1:0]      in_week,
   input  wire logic [MS_W-1:0]        in_time_ms,
   input  wire logic                   rsp_tready,
   output logic                        rsp_valid,
   output logic [SAMPLE_BITS-1:0]      out_residual,
   output logic [WEEK_W-1:0]           out_week,
   output logic [MS_W-1:0]             out_time_ms
);

   localparam int LINE_DEPTH = 2 * MAX_HALF_WINDOW + 1;
   localparam int HALF_W     = $clog2(MAX_HALF_WINDOW + 1);
   localparam int ADDR_W     = HALF_W + 1;
   localparam int SUM_W      = SAMPLE_BITS + ADDR_W;
   localparam int MAG_W      = SUM_W - 1;
   localparam int RES_W      = SUM_W + 1;
   localparam int LINE_W     = SAMPLE_BITS + WEEK_W + MS_W;

   logic [LINE_W-1:0] line_mem [LINE_DEPTH];
   logic [LINE_W-1:0] rd_data_ff;

   logic [CFG_W-1:0]         half_window_ff;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [ADDR_W-1:0]        count_ff, count_in;
   logic [ADDR_W-1:0]        ptr_ff, ptr_in;

   logic [SAMPLE_BITS-1:0] x_ff;
   logic [WEEK_W-1:0]      week_ff;
   logic [MS_W-1:0]        ms_ff;
   logic                   steady_ff, emit_ff;
   logic [HALF_W-1:0]      h_ff;
   logic [ADDR_W-1:0]      old_addr_ff, ctr_addr_ff;

   logic                   rsp_valid_ff;
   logic [SAMPLE_BITS-1:0] res_ff;
   logic [WEEK_W-1:0]      rweek_ff;
   logic [MS_W-1:0]        rms_ff;

   logic [HALF_W-1:0]  hw;
   logic [ADDR_W-1:0]  span;
   logic               steady;
   logic [HALF_W-1:0]  h_cur;
   logic [MAG_W-1:0]   mag;
   logic               sum_neg;
   logic [MAG_W-1:0]   quot;
   logic               div_done;
   logic [SAMPLE_BITS-1:0] res_sat;

   function automatic logic [ADDR_W-1:0] slot_back(input logic [ADDR_W-1:0] newest,
                                                   input logic [ADDR_W-1:0] back);
      logic [ADDR_W:0] t;
      t = {1'b0, newest} - {1'b0, back};
      if (t[ADDR_W]) begin
         t = t + (ADDR_W + 1)'(LINE_DEPTH);
      end
      return t[ADDR_W-1:0];
   endfunction

   // effective half window: zero acts as one, clamp at the maximum
   always_comb begin
      if (half_window_ff == '0) begin
         hw = HALF_W'(1);
      end else if (int'(half_window_ff) > MAX_HALF_WINDOW) begin
         hw = HALF_W'(MAX_HALF_WINDOW);
      end else begin
         hw = HALF_W'(half_window_ff);
      end
   end

   assign span   = {hw, 1'b1};
   assign steady = count_ff >= span;
   assign h_cur  = steady ? hw : count_ff[ADDR_W-1:1];

   // control registers: config restarts the stream
   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      ptr_in   = ptr_ff;
      if (cmd.write) begin
         sum_in = sum_ff + SUM_W'($signed(x_ff));
         if (steady_ff) begin
            sum_in = sum_in - SUM_W'($signed(rd_data_ff[SAMPLE_BITS-1:0]));
         end else begin
            count_in = count_ff + 1'b1;
         end
         ptr_in = (ptr_ff == ADDR_W'(LINE_DEPTH - 1)) ? '0 : ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_window_ff <= HALF_WINDOW_RESET;
         sum_ff         <= '0;
         count_ff       <= '0;
         ptr_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            half_window_ff <= csr_wr_data;
            sum_ff         <= '0;
            count_ff       <= '0;
            ptr_ff         <= '0;
         end else begin
            sum_ff   <= sum_in;
            count_ff <= count_in;
            ptr_ff   <= ptr_in;
         end
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // per-item capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         x_ff        <= in_sample;
         week_ff     <= in_week;
         ms_ff       <= in_time_ms;
         steady_ff   <= steady;
         emit_ff     <= steady | ~count_ff[0];
         h_ff        <= h_cur;
         old_addr_ff <= slot_back(ptr_ff, span);
         ctr_addr_ff <= slot_back(ptr_ff, ADDR_W'(h_cur));
      end
   end

   // delay line
   always_ff @(posedge clock) begin
      if (cmd.write) begin
         line_mem[ptr_ff] <= {ms_ff, week_ff, x_ff};
      end
      if (cmd.rd_old) begin
         rd_data_ff <= line_mem[old_addr_ff];
      end else if (cmd.rd_center) begin
         rd_data_ff <= line_mem[ctr_addr_ff];
      end
   end

   // round to nearest: (|sum| + h) / (2h+1), sign restored afterwards
   always_comb begin
      logic [SUM_W-1:0] abs_sum;
      sum_neg = sum_ff[SUM_W-1];
      abs_sum = sum_neg ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
      mag     = abs_sum[MAG_W-1:0] + MAG_W'(h_ff);
   end

   cmad_divider #(
      .NUM_W (MAG_W),
      .DEN_W (ADDR_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (mag),
      .divisor  ({h_ff, 1'b1}),
      .done     (div_done),
      .quotient (quot)
   );

   always_comb begin
      logic signed [RES_W-1:0] mean;
      logic signed [RES_W-1:0] ctr;
      logic signed [RES_W-1:0] diff;
      mean = $signed(RES_W'(quot));
      if (sum_neg) begin
         mean = -mean;
      end
      ctr  = RES_W'($signed(rd_data_ff[SAMPLE_BITS-1:0]));
      diff = ctr - mean;
      if (!diff[RES_W-1] && (diff[RES_W-1:SAMPLE_BITS-1] != '0)) begin
         res_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end else if (diff[RES_W-1] && (diff[RES_W-1:SAMPLE_BITS-1] != '1)) begin
         res_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         res_sat = diff[SAMPLE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         res_ff   <= res_sat;
         rweek_ff <= rd_data_ff[SAMPLE_BITS +: WEEK_W];
         rms_ff   <= rd_data_ff[SAMPLE_BITS+WEEK_W +: MS_W];
      end
   end

   assign status.emit     = emit_ff;
   assign status.div_done = div_done;
   assign status.out_full = rsp_valid_ff & ~rsp_tready;

   assign rsp_valid    = rsp_valid_ff;
   assign out_residual = res_ff;
   assign out_week     = rweek_ff;
   assign out_time_ms  = rms_ff;

`ifndef SYNTH
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      ptr_ff < ADDR_W'(LINE_DEPTH))
      else $error("write pointer past delay line");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= span)
      else $error("fill count beyond window");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_tready))
      else $error("output register overwritten");

   a_done_after_start: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> !div_done)
      else $error("divider done right after start");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/cmad_ctrl.sv -----
// Controller state machine sequencing delay-line access, division and output.
// Uses cmad_pkg for the state type and command/status structs.
`default_nettype none

module cmad_ctrl
   import cmad_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_READ_OLD;
            end
         end
         ST_READ_OLD: begin
            cmd.rd_old = 1'b1;
            state_in   = ST_WRITE;
         end
         ST_WRITE: begin
            cmd.write = 1'b1;
            state_in  = status.emit ? ST_READ_CTR : ST_IDLE;
         end
         ST_READ_CTR: begin
            cmd.rd_center = 1'b1;
            state_in      = ST_DIV_START;
         end
         ST_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (status.div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // hold until the previous word has left the output register
            if (!status.out_full) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- hw/rtl/centered_moving_average_detrend.sv -----
// Centered moving-average detrend: for each sample k the block returns
// x[k] minus the rounded mean of x[k-h..k+h], h = min(k, half_window), with
// the timestamp of sample k. One word is worked on at a time. A word that
// yields no result (odd inputs during warm-up) is captured, reads the old
// sample and is written; one with a result also reads the center, runs the
// two-bit-per-cycle mean divider and waits for a free output register. The
// last half_window samples of a stream are not flushed. Writing csr_wr_data
// restarts the stream; the delay line needs no clearing after reset.
// Depends on cmad_pkg, cmad_ctrl, cmad_datapath.
`default_nettype none

module centered_moving_average_detrend
   import cmad_pkg::*;
#(
   parameter int MAX_HALF_WINDOW = MAX_HALF_WINDOW_DEF,
   parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_wr_en,
   input  wire logic [CFG_W-1:0] csr_wr_data,   // half_window
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   // sample, week, time_ms, zero pad
   input  wire logic [((SAMPLE_BITS+WEEK_W+MS_W+7)/8)*8-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   // residual, out_week, out_time_ms, zero pad
   output logic [((SAMPLE_BITS+WEEK_W+MS_W+7)/8)*8-1:0]      rsp_tdata
);

   localparam int DATA_W = ((SAMPLE_BITS + WEEK_W + MS_W + 7) / 8) * 8;
   localparam int USED_W = SAMPLE_BITS + WEEK_W + MS_W;

   cmd_type    cmd;
   status_type status;

   logic [SAMPLE_BITS-1:0] residual;
   logic [WEEK_W-1:0]      out_week;
   logic [MS_W-1:0]        out_time_ms;

   cmad_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   cmad_datapath #(
      .MAX_HALF_WINDOW (MAX_HALF_WINDOW),
      .SAMPLE_BITS     (SAMPLE_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .cmd          (cmd),
      .status       (status),
      .in_sample    (req_tdata[SAMPLE_BITS-1:0]),
      .in_week      (req_tdata[SAMPLE_BITS +: WEEK_W]),
      .in_time_ms   (req_tdata[SAMPLE_BITS+WEEK_W +: MS_W]),
      .rsp_tready   (rsp_tready),
      .rsp_valid    (rsp_tvalid),
      .out_residual (residual),
      .out_week     (out_week),
      .out_time_ms  (out_time_ms)
   );

   assign rsp_tdata = DATA_W'({out_time_ms, out_week, residual});

   // pad bits of req_tdata above USED_W are ignored
   logic unused_pad;
   assign unused_pad = ^req_tdata[DATA_W-1:USED_W-1];

endmodule

`default_nettype wire
